### rtl/key_debounce_hold_repeat_assert.svh
// assertion macros for the key debounce block
`ifndef KEY_DEBOUNCE_HOLD_REPEAT_ASSERT_SVH
`define KEY_DEBOUNCE_HOLD_REPEAT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KDHR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kdhr same-cycle check failed");

// next-cycle implication, checked out of reset
`define KDHR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kdhr next-cycle check failed");

`endif

### rtl/kdhr_pkg.sv
// shared types and constants for the key debounce block
`default_nettype none

package kdhr_pkg;

   typedef enum logic [2:0] {
      PH_IGNORE   = 3'd0,
      PH_IDLE     = 3'd1,
      PH_DEBOUNCE = 3'd2,
      PH_HOLD     = 3'd3,
      PH_REPEAT   = 3'd4,
      PH_RELEASE  = 3'd5
   } phase_type;

   localparam logic [1:0] MODE_NORMAL     = 2'd0;
   localparam logic [1:0] MODE_KEY_UP     = 2'd1;
   localparam logic [1:0] MODE_SHORT_LONG = 2'd2;
   localparam logic [1:0] MODE_SPARE      = 2'd3;

   localparam logic [2:0] REG_DEBOUNCE      = 3'd0;
   localparam logic [2:0] REG_HOLD          = 3'd1;
   localparam logic [2:0] REG_REPEAT        = 3'd2;
   localparam logic [2:0] REG_MODE          = 3'd3;
   localparam logic [2:0] REG_FIRST_ENABLE  = 3'd4;
   localparam logic [2:0] REG_REPEAT_ENABLE = 3'd5;

   localparam int unsigned TickWidth = 16;
   localparam int unsigned IdWidth   = 7;

   typedef struct packed {
      logic [TickWidth-1:0] debounce_ticks;
      logic [TickWidth-1:0] hold_ticks;
      logic [TickWidth-1:0] repeat_ticks;
      logic [1:0]           mode;
      logic                 first_enable;
      logic                 repeat_enable;
   } cfg_type;

   typedef struct packed {
      phase_type            phase;
      logic [TickWidth-1:0] countdown;
      logic [IdWidth-1:0]   active_button;
   } state_type;

   typedef struct packed {
      logic       fire_repeat;
      logic       fire_first;
      logic       changed;
      phase_type  phase_code;
   } result_type;

endpackage

`default_nettype wire

### rtl/kdhr_step.sv
// one poll step of the shared debounce, hold and repeat machine
`default_nettype none

module kdhr_step
   import kdhr_pkg::*;
(
   input  wire cfg_type            cfg,
   input  wire state_type          st,
   input  wire logic [IdWidth-1:0] button_id,
   input  wire logic               pressed,
   output state_type               st_next,
   output result_type              result
);

   logic                 ignore;
   logic                 cd_zero;
   logic [1:0]           mode_eff;
   logic                 reload;
   logic [TickWidth-1:0] load;
   logic                 changed;
   logic                 fire_first;
   logic                 fire_repeat;

   assign ignore   = (st.active_button != '0) && (st.active_button != button_id);
   assign cd_zero  = (st.countdown == '0);
   assign mode_eff = (cfg.mode == MODE_SPARE) ? MODE_NORMAL : cfg.mode;

   // next state
   always_comb begin
      st_next.phase         = st.phase;
      st_next.active_button = st.active_button;
      reload                = 1'b0;
      load                  = cfg.debounce_ticks;
      if (!ignore) begin
         if (pressed && cd_zero) begin
            unique case (st.phase) inside
               PH_IDLE: begin
                  st_next.phase = PH_DEBOUNCE;
                  reload        = 1'b1;
               end
               PH_DEBOUNCE: begin
                  st_next.phase         = PH_HOLD;
                  reload                = 1'b1;
                  load                  = cfg.hold_ticks;
                  st_next.active_button = button_id;
               end
               PH_HOLD, PH_REPEAT: begin
                  st_next.phase = PH_REPEAT;
                  reload        = 1'b1;
                  load          = cfg.repeat_ticks;
               end
               default: ;
            endcase
         end else if (!pressed) begin
            unique case (st.phase) inside
               PH_HOLD, PH_REPEAT: begin
                  st_next.phase = PH_RELEASE;
                  reload        = !cd_zero;
               end
               PH_DEBOUNCE, PH_RELEASE: begin
                  if (cd_zero) begin
                     st_next.phase         = PH_IDLE;
                     st_next.active_button = '0;
                  end
               end
               default: ;
            endcase
         end
      end
      if (reload) begin
         st_next.countdown = load;
      end else if (!cd_zero) begin
         st_next.countdown = st.countdown - TickWidth'(1);
      end else begin
         st_next.countdown = st.countdown;
      end
   end

   // outputs
   always_comb begin
      changed     = 1'b0;
      fire_first  = 1'b0;
      fire_repeat = 1'b0;
      if (!ignore) begin
         if (pressed && cd_zero) begin
            unique case (st.phase)
               PH_IDLE: changed = 1'b1;
               PH_DEBOUNCE: begin
                  changed    = 1'b1;
                  fire_first = cfg.first_enable && (mode_eff == MODE_NORMAL);
               end
               PH_HOLD: begin
                  changed = 1'b1;
                  if (cfg.repeat_enable && (mode_eff != MODE_KEY_UP)) begin
                     fire_repeat = 1'b1;
                  end else begin
                     fire_first = cfg.first_enable && (mode_eff == MODE_SHORT_LONG);
                  end
               end
               PH_REPEAT: begin
                  changed     = 1'b1;
                  fire_repeat = cfg.repeat_enable && (mode_eff == MODE_NORMAL);
               end
               default: ;
            endcase
         end else if (!pressed) begin
            unique case (st.phase) inside
               PH_HOLD: begin
                  changed    = 1'b1;
                  // short press only counts when released before the hold ran out
                  fire_first = !cd_zero && cfg.first_enable && (mode_eff == MODE_SHORT_LONG);
               end
               PH_REPEAT: begin
                  changed    = 1'b1;
                  fire_first = !cd_zero && cfg.first_enable && (mode_eff == MODE_KEY_UP);
               end
               PH_DEBOUNCE, PH_RELEASE: changed = cd_zero;
               default: ;
            endcase
         end
      end
      result.phase_code  = ignore ? PH_IGNORE : st_next.phase;
      result.changed     = changed;
      result.fire_first  = fire_first;
      result.fire_repeat = fire_repeat;
   end

endmodule

`default_nettype wire

### rtl/key_debounce_hold_repeat.sv
// a word accepted into the input register is stepped into the result register and shown on rsp from there
// throughput: one poll word per cycle while rsp is not stalled; the single state step sets the pace
// a stalled result holds rsp; the input register can still take a word only while it is empty
// reset: synchronous, active high; phase idle, countdown zero, no active button,
// registers back to debounce 20, hold 500, repeat 100, mode 0, both actions on
`default_nettype none

`include "key_debounce_hold_repeat_assert.svh"

module key_debounce_hold_repeat
   import kdhr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // button_id [6:0], pressed [7]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // phase_code [2:0], changed [3], fire_first [4],
                                         // fire_repeat [5], zero [7:6]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type            cfg_ff;
   state_type          state_ff, state_in;
   result_type         result_in;
   result_type         out_ff;
   logic               out_valid_ff;
   logic               in_valid_ff;
   logic [IdWidth-1:0] in_id_ff;
   logic               in_pressed_ff;
   logic               advance;
   logic               accept;
   logic               cfg_write;
   logic [2:0]         reg_index;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= TickWidth'(20);
         cfg_ff.hold_ticks     <= TickWidth'(500);
         cfg_ff.repeat_ticks   <= TickWidth'(100);
         cfg_ff.mode           <= MODE_NORMAL;
         cfg_ff.first_enable   <= 1'b1;
         cfg_ff.repeat_enable  <= 1'b1;
      end else if (cfg_write) begin
         unique case (reg_index)
            REG_DEBOUNCE:      cfg_ff.debounce_ticks <= csr_pwdata[TickWidth-1:0];
            REG_HOLD:          cfg_ff.hold_ticks     <= csr_pwdata[TickWidth-1:0];
            REG_REPEAT:        cfg_ff.repeat_ticks   <= csr_pwdata[TickWidth-1:0];
            REG_MODE:          cfg_ff.mode           <= csr_pwdata[1:0];
            REG_FIRST_ENABLE:  cfg_ff.first_enable   <= csr_pwdata[0];
            REG_REPEAT_ENABLE: cfg_ff.repeat_enable  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DEBOUNCE:      csr_prdata = {16'd0, cfg_ff.debounce_ticks};
         REG_HOLD:          csr_prdata = {16'd0, cfg_ff.hold_ticks};
         REG_REPEAT:        csr_prdata = {16'd0, cfg_ff.repeat_ticks};
         REG_MODE:          csr_prdata = {30'd0, cfg_ff.mode};
         REG_FIRST_ENABLE:  csr_prdata = {31'd0, cfg_ff.first_enable};
         REG_REPEAT_ENABLE: csr_prdata = {31'd0, cfg_ff.repeat_enable};
         default:           csr_prdata = '0;
      endcase
   end

   // the step runs when the input register is full and the result slot is free or being taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_id_ff      <= req_tdata[6:0];
         in_pressed_ff <= req_tdata[7];
      end
   end

   kdhr_step u_step (
      .cfg       (cfg_ff),
      .st        (state_ff),
      .button_id (in_id_ff),
      .pressed   (in_pressed_ff),
      .st_next   (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_IDLE;
         state_ff.countdown     <= '0;
         state_ff.active_button <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

   `KDHR_ASSERT_NOW(a_one_action, out_valid_ff, !(out_ff.fire_first && out_ff.fire_repeat))
   `KDHR_ASSERT_NOW(a_ignored_quiet, out_valid_ff && (out_ff.phase_code == PH_IGNORE),
                    !out_ff.changed && !out_ff.fire_first && !out_ff.fire_repeat)
   `KDHR_ASSERT_NOW(a_owner_phase, state_ff.active_button != '0,
                    (state_ff.phase == PH_HOLD) || (state_ff.phase == PH_REPEAT) ||
                    (state_ff.phase == PH_RELEASE))
   `KDHR_ASSERT_NEXT(a_stall_keeps_word, in_valid_ff && !advance,
                     in_valid_ff && $stable(in_id_ff) && $stable(in_pressed_ff))

endmodule

`default_nettype wire
